// ===== rtl/bbpt_pkg.sv =====
package bbpt_pkg;

    // Fixed field widths of the price and result words.
    localparam int PRICE_BITS         = 24;
    localparam int POS_BITS           = 8;
    localparam int BAL_BITS           = 48;
    localparam int ORDER_BITS         = 2;
    localparam int WINDOW_MAX_DEFAULT = 64;

    // Configuration register widths, indexes and reset values.
    localparam int WLEN_BITS      = 7;
    localparam int PLIM_BITS      = 7;
    localparam int BMUL_BITS      = 4;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 7;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LENGTH   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_POSITION_LIMIT  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BAND_MULTIPLIER = 2'd2;

    localparam logic [WLEN_BITS-1:0] WLEN_RESET = 7'd20;
    localparam logic [PLIM_BITS-1:0] PLIM_RESET = 7'd5;
    localparam logic [BMUL_BITS-1:0] BMUL_RESET = 4'd2;

    // Order codes.
    localparam logic [ORDER_BITS-1:0] ORDER_NONE = 2'd0;
    localparam logic [ORDER_BITS-1:0] ORDER_BUY  = 2'd1;
    localparam logic [ORDER_BITS-1:0] ORDER_SELL = 2'd2;

    // Shared multiplier: one 32x32 product per step.
    localparam int MUL_BITS  = 32;
    localparam int PROD_BITS = 64;

    // Microprogram addresses.
    localparam int STEP_BITS = 4;
    localparam logic [STEP_BITS-1:0] STEP_START    = 4'd0;
    localparam logic [STEP_BITS-1:0] STEP_SQUARE   = 4'd1;
    localparam logic [STEP_BITS-1:0] STEP_SLIDE    = 4'd2;
    localparam logic [STEP_BITS-1:0] STEP_DIFF     = 4'd3;
    localparam logic [STEP_BITS-1:0] STEP_SUMSQ_LO = 4'd4;
    localparam logic [STEP_BITS-1:0] STEP_SUMSQ_HI = 4'd5;
    localparam logic [STEP_BITS-1:0] STEP_A_LO     = 4'd6;
    localparam logic [STEP_BITS-1:0] STEP_A_HI     = 4'd7;
    localparam logic [STEP_BITS-1:0] STEP_VAR      = 4'd8;
    localparam logic [STEP_BITS-1:0] STEP_D2_LO    = 4'd9;
    localparam logic [STEP_BITS-1:0] STEP_PV_LO    = 4'd10;
    localparam logic [STEP_BITS-1:0] STEP_D2_HI    = 4'd11;
    localparam logic [STEP_BITS-1:0] STEP_PV_HI    = 4'd12;
    localparam logic [STEP_BITS-1:0] STEP_TRADE    = 4'd13;
    localparam logic [STEP_BITS-1:0] STEP_MARK     = 4'd14;
    localparam logic [STEP_BITS-1:0] STEP_OUT      = 4'd15;

    // Datapath operations.
    localparam int OP_BITS = 4;
    localparam logic [OP_BITS-1:0] OP_NONE    = 4'd0;
    localparam logic [OP_BITS-1:0] OP_START   = 4'd1;
    localparam logic [OP_BITS-1:0] OP_SLIDE   = 4'd2;
    localparam logic [OP_BITS-1:0] OP_DIFF    = 4'd3;
    localparam logic [OP_BITS-1:0] OP_LATCH_B = 4'd4;
    localparam logic [OP_BITS-1:0] OP_LATCH_V = 4'd5;
    localparam logic [OP_BITS-1:0] OP_PV_LO   = 4'd6;
    localparam logic [OP_BITS-1:0] OP_PV_HI   = 4'd7;
    localparam logic [OP_BITS-1:0] OP_TRADE   = 4'd8;
    localparam logic [OP_BITS-1:0] OP_OUT     = 4'd9;

    // Accumulator operations on the previous product.
    localparam int ACC_BITS = 2;
    localparam logic [ACC_BITS-1:0] ACC_NONE     = 2'd0;
    localparam logic [ACC_BITS-1:0] ACC_LD       = 2'd1;
    localparam logic [ACC_BITS-1:0] ACC_ADD_SH32 = 2'd2;
    localparam logic [ACC_BITS-1:0] ACC_ADD_SH33 = 2'd3;

    // Multiplier operand sources.
    localparam int SEL_BITS  = 4;
    localparam int SEL_COUNT = 16;
    localparam logic [SEL_BITS-1:0] SEL_ZERO     = 4'd0;
    localparam logic [SEL_BITS-1:0] SEL_PRICE    = 4'd1;
    localparam logic [SEL_BITS-1:0] SEL_OLD      = 4'd2;
    localparam logic [SEL_BITS-1:0] SEL_N        = 4'd3;
    localparam logic [SEL_BITS-1:0] SEL_SUM_LO   = 4'd4;
    localparam logic [SEL_BITS-1:0] SEL_SUM_HI   = 4'd5;
    localparam logic [SEL_BITS-1:0] SEL_SQ_LO    = 4'd6;
    localparam logic [SEL_BITS-1:0] SEL_SQ_HI    = 4'd7;
    localparam logic [SEL_BITS-1:0] SEL_D_LO     = 4'd8;
    localparam logic [SEL_BITS-1:0] SEL_D_HI     = 4'd9;
    localparam logic [SEL_BITS-1:0] SEL_V_LO     = 4'd10;
    localparam logic [SEL_BITS-1:0] SEL_V_HI     = 4'd11;
    localparam logic [SEL_BITS-1:0] SEL_PP       = 4'd12;
    localparam logic [SEL_BITS-1:0] SEL_HELD_MAG = 4'd13;

    // Jump conditions.
    localparam logic COND_NEVER   = 1'b0;
    localparam logic COND_NO_TEST = 1'b1;

    typedef struct packed {
        logic [PRICE_BITS-1:0] price;
        logic                  trade_enable;
    } price_word_t;

    typedef struct packed {
        logic [ORDER_BITS-1:0]      order;
        logic signed [POS_BITS-1:0] position;
        logic signed [BAL_BITS-1:0] balance;
        logic signed [BAL_BITS-1:0] equity;
        logic                       window_not_full;
    } result_word_t;

    typedef struct packed {
        logic [OP_BITS-1:0]   op;
        logic [ACC_BITS-1:0]  acc;
        logic [SEL_BITS-1:0]  sel_a;
        logic [SEL_BITS-1:0]  sel_b;
        logic                 cond;
        logic [STEP_BITS-1:0] target;
    } ucw_t;

    // Control store. Each step issues one product and uses the product of
    // the step before it.
    function automatic ucw_t ucode(input logic [STEP_BITS-1:0] step);
        ucw_t w;
        w.op     = OP_NONE;
        w.acc    = ACC_NONE;
        w.sel_a  = SEL_ZERO;
        w.sel_b  = SEL_ZERO;
        w.cond   = COND_NEVER;
        w.target = STEP_START;
        case (step)
            STEP_START: begin
                w.op = OP_START;
                w.sel_a = SEL_PRICE;
                w.sel_b = SEL_PRICE;
            end
            STEP_SQUARE: begin
                w.acc = ACC_LD;
                w.sel_a = SEL_OLD;
                w.sel_b = SEL_OLD;
            end
            STEP_SLIDE: begin
                w.op = OP_SLIDE;
                w.sel_a = SEL_N;
                w.sel_b = SEL_PRICE;
            end
            STEP_DIFF: begin
                w.op = OP_DIFF;
                w.sel_a = SEL_SUM_LO;
                w.sel_b = SEL_SUM_LO;
                w.cond = COND_NO_TEST;
                w.target = STEP_MARK;
            end
            STEP_SUMSQ_LO: begin
                w.acc = ACC_LD;
                w.sel_a = SEL_SUM_LO;
                w.sel_b = SEL_SUM_HI;
            end
            STEP_SUMSQ_HI: begin
                w.acc = ACC_ADD_SH33;
                w.sel_a = SEL_N;
                w.sel_b = SEL_SQ_LO;
            end
            STEP_A_LO: begin
                w.op = OP_LATCH_B;
                w.acc = ACC_LD;
                w.sel_a = SEL_N;
                w.sel_b = SEL_SQ_HI;
            end
            STEP_A_HI: begin
                w.acc = ACC_ADD_SH32;
            end
            STEP_VAR: begin
                w.op = OP_LATCH_V;
                w.sel_a = SEL_D_LO;
                w.sel_b = SEL_D_LO;
            end
            STEP_D2_LO: begin
                w.acc = ACC_LD;
                w.sel_a = SEL_PP;
                w.sel_b = SEL_V_LO;
            end
            STEP_PV_LO: begin
                w.op = OP_PV_LO;
                w.sel_a = SEL_D_LO;
                w.sel_b = SEL_D_HI;
            end
            STEP_D2_HI: begin
                w.acc = ACC_ADD_SH33;
                w.sel_a = SEL_PP;
                w.sel_b = SEL_V_HI;
            end
            STEP_PV_HI: begin
                w.op = OP_PV_HI;
            end
            STEP_TRADE: begin
                w.op = OP_TRADE;
            end
            STEP_MARK: begin
                w.sel_a = SEL_HELD_MAG;
                w.sel_b = SEL_PRICE;
            end
            STEP_OUT: begin
                w.op = OP_OUT;
                w.sel_a = SEL_HELD_MAG;
                w.sel_b = SEL_PRICE;
            end
            default: begin
                w.op = OP_NONE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/bollinger_band_position_trader_unit.sv =====
// Channel   Direction  Handshake                  Word
// price     in         price_valid / price_stall  price_word (price, trade_enable)
// result    out        result_valid / result_stall result_word (order .. window_not_full)
// cfg       in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A trading word with a full window runs all steps of the 16-step microprogram; any
// other word jumps from the difference step to the mark step. The microprogram runs
// every product through one shared 32x32 multiplier.
// Reset (rst_n, asynchronous, low) empties the window, clears position and
// balance and loads the registers with 20, 5 and 2. The price ring needs no
// clearing pass: only entries written since the window was last emptied are read.
// price_stall is high while the program runs; the result waits in an output
// register, and the program holds at its last step until that register is free.
module bollinger_band_position_trader_unit #(
    parameter int WINDOW_MAX = bbpt_pkg::WINDOW_MAX_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   price_valid,
    output logic                                   price_stall,
    input  bbpt_pkg::price_word_t                  price_word,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output bbpt_pkg::result_word_t                 result_word,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bbpt_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [bbpt_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int NW    = $clog2(WINDOW_MAX + 1);
    localparam int PB    = bbpt_pkg::PRICE_BITS;
    localparam int SUM_W = PB + NW;
    localparam int SQ_W  = 2 * PB + NW;
    localparam int PRW   = bbpt_pkg::PROD_BITS;
    localparam int MW    = bbpt_pkg::MUL_BITS;
    localparam int PV_W  = PRW + 2 * bbpt_pkg::BMUL_BITS;
    localparam int BW    = bbpt_pkg::BAL_BITS;
    localparam int SW    = bbpt_pkg::STEP_BITS;

    // Control state.
    logic                              busy_reg, busy_next;
    logic [SW-1:0]                     step_reg, step_next;
    logic [bbpt_pkg::WLEN_BITS-1:0]    wlen_reg, wlen_next;
    logic [bbpt_pkg::PLIM_BITS-1:0]    plim_reg, plim_next;
    logic [bbpt_pkg::BMUL_BITS-1:0]    bmul_reg, bmul_next;
    logic [AW-1:0]                     wp_reg, wp_next;
    logic [NW-1:0]                     fill_reg, fill_next;
    logic [SUM_W-1:0]                  sum_reg, sum_next;
    logic [SQ_W-1:0]                   sq_reg, sq_next;
    logic signed [bbpt_pkg::POS_BITS-1:0] held_reg, held_next;
    logic [BW-1:0]                     cash_reg, cash_next;
    logic                              res_valid_reg, res_valid_next;

    // Datapath registers.
    logic [PB-1:0]                     price_reg, price_next;
    logic                              trade_reg, trade_next;
    logic [PRW-1:0]                    prod_reg, prod_next;
    logic [PRW-1:0]                    acc_reg, acc_next;
    logic [SUM_W-1:0]                  d_reg, d_next;
    logic                              nonneg_reg, nonneg_next;
    logic                              nonpos_reg, nonpos_next;
    logic [PRW-1:0]                    b_reg, b_next;
    logic [PRW-1:0]                    v_reg, v_next;
    logic [PV_W-1:0]                   pv_reg, pv_next;
    logic [bbpt_pkg::ORDER_BITS-1:0]   order_reg, order_next;
    logic                              nf_reg, nf_next;
    bbpt_pkg::result_word_t            res_word_reg, res_word_next;

    // Price ring.
    logic [PB-1:0]                     ring_mem [WINDOW_MAX];
    logic [PB-1:0]                     ring_rd_reg;
    logic                              ring_rd_en;
    logic                              ring_wr_en;
    logic [AW-1:0]                     old_idx;
    logic [NW-1:0]                     wp_ext;
    logic [NW-1:0]                     old_idx_w;

    // Decoded and derived values.
    bbpt_pkg::ucw_t                    uw;
    logic [NW-1:0]                     n_eff;
    logic [2*bbpt_pkg::BMUL_BITS-1:0]  pp;
    logic                              full;
    logic                              take_test;
    logic                              out_free;
    logic                              price_acc;
    logic                              cfg_acc;
    logic [bbpt_pkg::POS_BITS-1:0]     held_mag;
    logic signed [bbpt_pkg::POS_BITS-1:0] lim_s;
    logic                              wide;
    logic                              buy_ok;
    logic                              sell_ok;
    logic [SUM_W-1:0]                  np;
    logic [PRW-1:0]                    sum64;
    logic [PRW-1:0]                    sq64;
    logic [PRW-1:0]                    d64;
    logic [MW-1:0]                     opnd [bbpt_pkg::SEL_COUNT];
    logic [MW-1:0]                     mul_a;
    logic [MW-1:0]                     mul_b;

    assign uw          = bbpt_pkg::ucode(step_reg);
    assign price_stall = busy_reg;
    assign cfg_ready   = !busy_reg;
    assign price_acc   = price_valid && !price_stall;
    assign cfg_acc     = cfg_valid && cfg_ready;
    assign out_free    = !res_valid_reg || !result_stall;
    assign result_valid = res_valid_reg;
    assign result_word  = res_word_reg;

    // Effective window length: zero acts as one, oversize clamps to the ring depth.
    always_comb
    begin
        if (wlen_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (int'(wlen_reg) > WINDOW_MAX)
        begin
            n_eff = NW'(WINDOW_MAX);
        end
        else
        begin
            n_eff = NW'(wlen_reg);
        end
    end

    assign pp        = {{bbpt_pkg::BMUL_BITS{1'b0}}, bmul_reg} *
                       {{bbpt_pkg::BMUL_BITS{1'b0}}, bmul_reg};
    assign full      = fill_reg >= n_eff;
    assign take_test = trade_reg && full;
    assign held_mag  = held_reg[bbpt_pkg::POS_BITS-1] ? bbpt_pkg::POS_BITS'(-held_reg)
                                                      : bbpt_pkg::POS_BITS'(held_reg);
    assign lim_s     = signed'({1'b0, plim_reg});
    assign np        = prod_reg[SUM_W-1:0];

    // The accumulator holds the squared distance when the trade step runs.
    assign wide    = {{(PV_W-PRW){1'b0}}, acc_reg} >= pv_reg;
    assign buy_ok  = nonneg_reg && wide && (held_reg < lim_s);
    assign sell_ok = nonpos_reg && wide && (held_reg > -lim_s);

    // Slot of the price that leaves the window.
    assign wp_ext    = NW'(wp_reg);
    assign old_idx_w = (wp_ext >= n_eff) ? (wp_ext - n_eff)
                                         : (wp_ext + NW'(WINDOW_MAX) - n_eff);
    assign old_idx   = AW'(old_idx_w);

    assign ring_rd_en = busy_reg && (uw.op == bbpt_pkg::OP_START);
    assign ring_wr_en = busy_reg && (uw.op == bbpt_pkg::OP_SLIDE);

    // Multiplier operand sources, split into 32-bit halves.
    assign sum64 = PRW'(sum_reg);
    assign sq64  = PRW'(sq_reg);
    assign d64   = PRW'(d_reg);

    always_comb
    begin
        for (int i = 0; i < bbpt_pkg::SEL_COUNT; i++)
        begin
            opnd[i] = '0;
        end
        opnd[bbpt_pkg::SEL_PRICE]    = MW'(price_reg);
        opnd[bbpt_pkg::SEL_OLD]      = MW'(ring_rd_reg);
        opnd[bbpt_pkg::SEL_N]        = MW'(n_eff);
        opnd[bbpt_pkg::SEL_SUM_LO]   = sum64[MW-1:0];
        opnd[bbpt_pkg::SEL_SUM_HI]   = sum64[PRW-1:MW];
        opnd[bbpt_pkg::SEL_SQ_LO]    = sq64[MW-1:0];
        opnd[bbpt_pkg::SEL_SQ_HI]    = sq64[PRW-1:MW];
        opnd[bbpt_pkg::SEL_D_LO]     = d64[MW-1:0];
        opnd[bbpt_pkg::SEL_D_HI]     = d64[PRW-1:MW];
        opnd[bbpt_pkg::SEL_V_LO]     = v_reg[MW-1:0];
        opnd[bbpt_pkg::SEL_V_HI]     = v_reg[PRW-1:MW];
        opnd[bbpt_pkg::SEL_PP]       = MW'(pp);
        opnd[bbpt_pkg::SEL_HELD_MAG] = MW'(held_mag);
        mul_a = opnd[uw.sel_a];
        mul_b = opnd[uw.sel_b];
    end

    // Sequencer and datapath next state.
    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        wlen_next      = wlen_reg;
        plim_next      = plim_reg;
        bmul_next      = bmul_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        sq_next        = sq_reg;
        held_next      = held_reg;
        cash_next      = cash_reg;
        res_valid_next = res_valid_reg;
        price_next     = price_reg;
        trade_next     = trade_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        d_next         = d_reg;
        nonneg_next    = nonneg_reg;
        nonpos_next    = nonpos_reg;
        b_next         = b_reg;
        v_next         = v_reg;
        pv_next        = pv_reg;
        order_next     = order_reg;
        nf_next        = nf_reg;
        res_word_next  = res_word_reg;

        // Register writes; a window length write empties the window.
        if (cfg_acc)
        begin
            case (cfg_index)
                bbpt_pkg::CFG_WINDOW_LENGTH:
                begin
                    wlen_next = cfg_data;
                    wp_next   = '0;
                    fill_next = '0;
                    sum_next  = '0;
                    sq_next   = '0;
                end
                bbpt_pkg::CFG_POSITION_LIMIT:
                begin
                    plim_next = cfg_data;
                end
                bbpt_pkg::CFG_BAND_MULTIPLIER:
                begin
                    bmul_next = cfg_data[bbpt_pkg::BMUL_BITS-1:0];
                end
                default:
                begin
                    wlen_next = wlen_reg;
                end
            endcase
        end

        // Output register drains when the far side takes the word.
        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        // Accept a price word and start the program.
        if (price_acc)
        begin
            busy_next  = 1'b1;
            step_next  = bbpt_pkg::STEP_START;
            price_next = price_word.price;
            trade_next = price_word.trade_enable;
        end

        if (busy_reg)
        begin
            // Step counter with one conditional jump past the band test.
            if ((uw.cond == bbpt_pkg::COND_NO_TEST) && !take_test)
            begin
                step_next = uw.target;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end

            // Shared multiplier, registered.
            prod_next = PRW'(mul_a) * PRW'(mul_b);

            // Accumulator works on the previous step's product.
            case (uw.acc)
                bbpt_pkg::ACC_LD:       acc_next = prod_reg;
                bbpt_pkg::ACC_ADD_SH32: acc_next = acc_reg + {prod_reg[PRW-MW-1:0], {MW{1'b0}}};
                bbpt_pkg::ACC_ADD_SH33: acc_next = acc_reg +
                                                   {prod_reg[PRW-MW-2:0], {(MW+1){1'b0}}};
                default:                acc_next = acc_reg;
            endcase

            case (uw.op)
                bbpt_pkg::OP_START:
                begin
                    order_next = bbpt_pkg::ORDER_NONE;
                    nf_next    = 1'b0;
                end
                bbpt_pkg::OP_SLIDE:
                begin
                    // Accumulator holds price squared, product holds the old price squared.
                    sum_next  = sum_reg - (full ? SUM_W'(ring_rd_reg) : '0) + SUM_W'(price_reg);
                    sq_next   = sq_reg - (full ? prod_reg[SQ_W-1:0] : '0) + acc_reg[SQ_W-1:0];
                    fill_next = full ? n_eff : fill_reg + 1'b1;
                    wp_next   = (wp_reg == AW'(WINDOW_MAX - 1)) ? '0 : wp_reg + 1'b1;
                end
                bbpt_pkg::OP_DIFF:
                begin
                    nonneg_next = np >= sum_reg;
                    nonpos_next = np <= sum_reg;
                    d_next      = (np >= sum_reg) ? (np - sum_reg) : (sum_reg - np);
                    nf_next     = trade_reg && !full;
                end
                bbpt_pkg::OP_LATCH_B:
                begin
                    b_next = acc_reg;
                end
                bbpt_pkg::OP_LATCH_V:
                begin
                    v_next = (acc_reg >= b_reg) ? (acc_reg - b_reg) : '0;
                end
                bbpt_pkg::OP_PV_LO:
                begin
                    pv_next = PV_W'(prod_reg);
                end
                bbpt_pkg::OP_PV_HI:
                begin
                    pv_next = pv_reg + {prod_reg[PV_W-MW-1:0], {MW{1'b0}}};
                end
                bbpt_pkg::OP_TRADE:
                begin
                    if (buy_ok)
                    begin
                        held_next  = held_reg + 8'sd1;
                        cash_next  = cash_reg - BW'(price_reg);
                        order_next = bbpt_pkg::ORDER_BUY;
                    end
                    else if (sell_ok)
                    begin
                        held_next  = held_reg - 8'sd1;
                        cash_next  = cash_reg + BW'(price_reg);
                        order_next = bbpt_pkg::ORDER_SELL;
                    end
                end
                bbpt_pkg::OP_OUT:
                begin
                    // Product holds |position| times price for the square-off value.
                    step_next = step_reg;
                    if (out_free)
                    begin
                        busy_next                     = 1'b0;
                        res_valid_next                = 1'b1;
                        res_word_next.order           = order_reg;
                        res_word_next.position        = held_reg;
                        res_word_next.balance         = cash_reg;
                        res_word_next.equity          = held_reg[bbpt_pkg::POS_BITS-1]
                                                        ? (cash_reg - prod_reg[BW-1:0])
                                                        : (cash_reg + prod_reg[BW-1:0]);
                        res_word_next.window_not_full = nf_reg;
                    end
                end
                default:
                begin
                    nf_next = nf_reg;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= bbpt_pkg::STEP_START;
            wlen_reg      <= bbpt_pkg::WLEN_RESET;
            plim_reg      <= bbpt_pkg::PLIM_RESET;
            bmul_reg      <= bbpt_pkg::BMUL_RESET;
            wp_reg        <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            sq_reg        <= '0;
            held_reg      <= '0;
            cash_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            wlen_reg      <= wlen_next;
            plim_reg      <= plim_next;
            bmul_reg      <= bmul_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            sq_reg        <= sq_next;
            held_reg      <= held_next;
            cash_reg      <= cash_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        price_reg    <= price_next;
        trade_reg    <= trade_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        d_reg        <= d_next;
        nonneg_reg   <= nonneg_next;
        nonpos_reg   <= nonpos_next;
        b_reg        <= b_next;
        v_reg        <= v_next;
        pv_reg       <= pv_next;
        order_reg    <= order_next;
        nf_reg       <= nf_next;
        res_word_reg <= res_word_next;
    end

    // Price ring: registered read of the leaving price, write of the new one.
    always_ff @(posedge clk)
    begin
        if (ring_rd_en)
        begin
            ring_rd_reg <= ring_mem[old_idx];
        end
        if (ring_wr_en)
        begin
            ring_mem[wp_reg] <= price_reg;
        end
    end

    // The fill count never runs past the window length.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= n_eff)
        else $error("fill count exceeds window length");

    // An empty window carries no sums.
    a_empty_sums: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> ((sum_reg == '0) && (sq_reg == '0)))
        else $error("empty window with nonzero sums");

    // The trade step is reached only for a trading word with a full window.
    a_trade_guard: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && (step_reg == bbpt_pkg::STEP_TRADE)) |-> (trade_reg && full))
        else $error("band test reached without a full window");

    // An accepted word starts the program at its first step.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        price_acc |=> (busy_reg && (step_reg == bbpt_pkg::STEP_START)))
        else $error("accepted word did not start the program");

    // Position never reaches the most negative code.
    a_position: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg[bbpt_pkg::POS_BITS-1] |-> (held_reg[bbpt_pkg::POS_BITS-2:0] != '0))
        else $error("position out of range");

endmodule
